// File: sv/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and helpers of the millisecond calendar counter
// payload structs, command codes, remainder step, month table, leap rule
// ----------------------------------------------------------------------------
package mcc_pkg;

  // milliseconds in one second
  localparam int MS_PER_SECOND = 1000;

  localparam int TS_W      = 64;
  localparam int REM_W     = $clog2(MS_PER_SECOND);
  localparam int DIGIT_W   = 8;
  localparam int NUM_STAGES = TS_W / DIGIT_W;

  localparam logic [REM_W:0] MS_MOD = (REM_W + 1)'(MS_PER_SECOND);

  localparam logic [6:0] SEC_PER_MIN  = 7'd60;
  localparam logic [6:0] MIN_PER_HOUR = 7'd60;
  localparam logic [5:0] HOUR_PER_DAY = 6'd24;
  localparam logic [2:0] WEEKDAY_LAST = 3'd7;
  localparam logic [3:0] MONTH_FIRST  = 4'd1;
  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [3:0] MONTH_LAST   = 4'd12;

  // divisibility by 25 through the modular inverse of 25 mod 2^16
  localparam logic [15:0] INV25 = 16'h5C29;
  localparam logic [15:0] LIM25 = 16'(16'hFFFF / 25);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] new_timestamp;
    logic [5:0]  new_second;
    logic [5:0]  new_minute;
    logic [4:0]  new_hour;
    logic [2:0]  new_week_day;
    logic [4:0]  new_month_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
  } in_item_t;

  typedef struct packed {
    logic [63:0] now_timestamp;
    logic [5:0]  now_second;
    logic [5:0]  now_minute;
    logic [4:0]  now_hour;
    logic [2:0]  now_week_day;
    logic [4:0]  now_month_day;
    logic [3:0]  now_month;
    logic [15:0] now_year;
    logic        is_running;
  } out_item_t;

  // item in flight through the remainder pipeline
  typedef struct packed {
    in_item_t         item;
    logic [REM_W-1:0] rem;
    logic [TS_W-1:0]  digits;
  } mod_item_t;

  // one digit of long division by the second length
  function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] rem_in,
                                                input logic [DIGIT_W-1:0] dig);
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    r = rem_in;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, dig[i]};
      if (t >= MS_MOD) begin
        t = t - MS_MOD;
      end
      r = t[REM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // gregorian rule
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] q;
    logic        d4;
    logic        d16;
    logic        d25;
    q   = y * INV25;
    d25 = (q <= LIM25);
    d4  = (y[1:0] == 2'd0);
    d16 = (y[3:0] == 4'd0);
    return d4 && (!d25 || d16);
  endfunction

endpackage

// File: sv/mcc_mod_stage.sv
// ----------------------------------------------------------------------------
// mcc_mod_stage: one registered step of the timestamp remainder pipeline
// folds the next timestamp digit into the running remainder
// ----------------------------------------------------------------------------
module mcc_mod_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  mcc_pkg::mod_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output mcc_pkg::mod_item_t dn_item
);

  logic               valid_r;
  logic               valid_nxt;
  mcc_pkg::mod_item_t item_r;
  mcc_pkg::mod_item_t item_nxt;
  logic               take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  always_comb begin
    item_nxt      = up_item;
    item_nxt.rem  = mcc_pkg::rem_step(up_item.rem,
                      up_item.digits[mcc_pkg::TS_W-1 -: mcc_pkg::DIGIT_W]);
    item_nxt.digits = {up_item.digits[mcc_pkg::TS_W-mcc_pkg::DIGIT_W-1:0],
                       {mcc_pkg::DIGIT_W{1'b0}}};
    if (take) begin
      valid_nxt = 1'b1;
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// File: sv/mcc_calendar.sv
// ----------------------------------------------------------------------------
// mcc_calendar: clock state and result register
// applies one command per transfer and registers the time and date after it
// ----------------------------------------------------------------------------
module mcc_calendar (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  mcc_pkg::mod_item_t up_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mcc_pkg::out_item_t out_data
);

  logic [63:0]              total_r, total_nxt;
  logic [mcc_pkg::REM_W-1:0] phase_r, phase_nxt;
  logic [5:0]               sec_r, sec_nxt;
  logic [5:0]               min_r, min_nxt;
  logic [4:0]               hour_r, hour_nxt;
  logic [2:0]               wday_r, wday_nxt;
  logic [4:0]               mday_r, mday_nxt;
  logic [3:0]               month_r, month_nxt;
  logic [15:0]              year_r, year_nxt;
  logic                     leap_r, leap_nxt;
  logic                     run_r, run_nxt;
  logic                     out_valid_r, out_valid_nxt;
  mcc_pkg::out_item_t       out_data_r, out_data_nxt;

  logic                     take;
  logic [mcc_pkg::REM_W:0]  phase_inc;
  logic                     boundary;
  logic [6:0]               sec_inc;
  logic [6:0]               min_inc;
  logic [5:0]               hour_inc;
  logic                     sec_wrap, min_wrap, hour_wrap;
  logic                     day_carry;
  logic                     month_ok;
  logic [5:0]               len;
  logic [5:0]               day_inc;
  logic [15:0]              year_inc;
  logic [15:0]              leap_year;
  logic                     leap_calc;

  assign up_ready = !out_valid_r || out_ready;
  assign take     = up_valid && up_ready;

  always_comb begin
    phase_inc = {1'b0, phase_r} + {{mcc_pkg::REM_W{1'b0}}, 1'b1};
    boundary  = (phase_inc == mcc_pkg::MS_MOD) || (&total_r);
    sec_inc   = {1'b0, sec_r} + 7'd1;
    min_inc   = {1'b0, min_r} + 7'd1;
    hour_inc  = {1'b0, hour_r} + 6'd1;
    sec_wrap  = (sec_inc >= mcc_pkg::SEC_PER_MIN);
    min_wrap  = (min_inc >= mcc_pkg::MIN_PER_HOUR);
    hour_wrap = (hour_inc >= mcc_pkg::HOUR_PER_DAY);
    day_carry = sec_wrap && min_wrap && hour_wrap;
    month_ok  = (month_r >= mcc_pkg::MONTH_FIRST) && (month_r <= mcc_pkg::MONTH_LAST);
    len       = {1'b0, mcc_pkg::month_len(month_r)} +
                {5'd0, (month_r == mcc_pkg::MONTH_FEB) && leap_r};
    day_inc   = {1'b0, mday_r} + 6'd1;
    year_inc  = year_r + 16'd1;
    // one leap unit serves both the set path and the year rollover
    leap_year = (up_item.item.command == mcc_pkg::CMD_SET) ? up_item.item.new_year
                                                            : year_inc;
    leap_calc = mcc_pkg::is_leap(leap_year);

    total_nxt = total_r;
    phase_nxt = phase_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    wday_nxt  = wday_r;
    mday_nxt  = mday_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    leap_nxt  = leap_r;
    run_nxt   = run_r;

    case (up_item.item.command)
      mcc_pkg::CMD_TICK: begin
        if (run_r) begin
          total_nxt = total_r + 64'd1;
          phase_nxt = boundary ? '0 : phase_inc[mcc_pkg::REM_W-1:0];
          if (boundary) begin
            sec_nxt = sec_wrap ? 6'd0 : sec_inc[5:0];
            if (sec_wrap) begin
              min_nxt = min_wrap ? 6'd0 : min_inc[5:0];
            end
            if (sec_wrap && min_wrap) begin
              hour_nxt = hour_wrap ? 5'd0 : hour_inc[4:0];
            end
            if (day_carry) begin
              wday_nxt = (wday_r >= mcc_pkg::WEEKDAY_LAST || wday_r == 3'd0) ?
                         3'd1 : wday_r + 3'd1;
              if (!month_ok) begin
                mday_nxt = day_inc[4:0];
              end else if (day_inc > len) begin
                mday_nxt = 5'd1;
                if (month_r == mcc_pkg::MONTH_LAST) begin
                  month_nxt = mcc_pkg::MONTH_FIRST;
                  year_nxt  = year_inc;
                  leap_nxt  = leap_calc;
                end else begin
                  month_nxt = month_r + 4'd1;
                end
              end else begin
                mday_nxt = day_inc[4:0];
              end
            end
          end
        end
      end
      mcc_pkg::CMD_SET: begin
        total_nxt = up_item.item.new_timestamp;
        phase_nxt = up_item.rem;
        sec_nxt   = up_item.item.new_second;
        min_nxt   = up_item.item.new_minute;
        hour_nxt  = up_item.item.new_hour;
        wday_nxt  = up_item.item.new_week_day;
        mday_nxt  = up_item.item.new_month_day;
        month_nxt = up_item.item.new_month;
        year_nxt  = up_item.item.new_year;
        leap_nxt  = leap_calc;
      end
      mcc_pkg::CMD_START: begin
        run_nxt = 1'b1;
      end
      mcc_pkg::CMD_STOP: begin
        run_nxt = 1'b0;
      end
      default: begin
        run_nxt = run_r;
      end
    endcase

    out_data_nxt.now_timestamp = total_nxt;
    out_data_nxt.now_second    = sec_nxt;
    out_data_nxt.now_minute    = min_nxt;
    out_data_nxt.now_hour      = hour_nxt;
    out_data_nxt.now_week_day  = wday_nxt;
    out_data_nxt.now_month_day = mday_nxt;
    out_data_nxt.now_month     = month_nxt;
    out_data_nxt.now_year      = year_nxt;
    out_data_nxt.is_running    = run_nxt;

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= 64'd0;
      phase_r     <= '0;
      sec_r       <= 6'd0;
      min_r       <= 6'd0;
      hour_r      <= 5'd0;
      wday_r      <= 3'd1;
      mday_r      <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= 16'd2000;
      leap_r      <= 1'b1;
      run_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        total_r <= total_nxt;
        phase_r <= phase_nxt;
        sec_r   <= sec_nxt;
        min_r   <= min_nxt;
        hour_r  <= hour_nxt;
        wday_r  <= wday_nxt;
        mday_r  <= mday_nxt;
        month_r <= month_nxt;
        year_r  <= year_nxt;
        leap_r  <= leap_nxt;
        run_r   <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/millisecond_calendar_counter.sv
// ----------------------------------------------------------------------------
// millisecond_calendar_counter: millisecond timestamp with calendar
// tick, set, start and stop commands; one time and date result per command
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready/in_data carry one command per transfer: tick adds one
//   millisecond while running, set loads timestamp and all time and date fields,
//   start and stop switch the running flag
//   out_valid/out_ready/out_data carry one result per command: timestamp,
//   time of day, weekday, date and running flag after that command
//   pipeline: a result passes one registered stage per timestamp digit of
//   the remainder pipeline (8 digits of 8 bits, so the second phase of a
//   loaded timestamp is known) and then the calendar update stage
//   throughput: one command per cycle while the receiver keeps up; the calendar
//   stage updates all state on each transfer, so back-to-back ticks and sets need no bubbles
//   reset: timestamp 0, 00:00:00, weekday 1, January 1st 2000 (leap),
//   running; the pipeline comes out of reset empty
//   stall: each stage holds its item while the one after it is full, so a
//   stalled receiver fills the pipeline and then drops in_ready
// ----------------------------------------------------------------------------
module millisecond_calendar_counter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mcc_pkg::out_item_t out_data
);

  // handshake and payload between pipeline stages, index 0 is the input port
  logic               stg_valid [mcc_pkg::NUM_STAGES+1];
  logic               stg_ready [mcc_pkg::NUM_STAGES+1];
  mcc_pkg::mod_item_t stg_item  [mcc_pkg::NUM_STAGES+1];

  // remainder starts at zero, digits are the timestamp, msb first
  assign stg_item[0] = {in_data, {mcc_pkg::REM_W{1'b0}}, in_data.new_timestamp};

  assign stg_valid[0] = in_valid;
  assign in_ready     = stg_ready[0];

  // one digit of timestamp mod ms-per-second per stage
  for (genvar g = 0; g < mcc_pkg::NUM_STAGES; g++) begin : g_mod
    mcc_mod_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_item  (stg_item[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_item  (stg_item[g+1])
    );
  end

  // calendar state and result register
  mcc_calendar u_calendar (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (stg_valid[mcc_pkg::NUM_STAGES]),
    .up_ready  (stg_ready[mcc_pkg::NUM_STAGES]),
    .up_item   (stg_item[mcc_pkg::NUM_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/millisecond_calendar_counter_tb.sv
// ----------------------------------------------------------------------------
// millisecond_calendar_counter_tb: self-checking bench for the calendar clock
// drives tick, set, start and stop commands through the valid/ready input,
// predicts every time and date result with an in-bench calendar and compares
// each returned result field by field, under random sender bursts and
// receiver stalls
// ----------------------------------------------------------------------------
module millisecond_calendar_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mcc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mcc_pkg::out_item_t out_data;

  millisecond_calendar_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predicted calendar state, kept wider than the hardware fields so that
  // out-of-range values loaded by a set carry exactly as they should
  logic [63:0] clock_ms;
  int unsigned cal_sec, cal_min, cal_hour, cal_wday;
  int unsigned cal_mday, cal_month, cal_year;
  bit          cal_leap, cal_running;

  // results still owed by the block, oldest first
  mcc_pkg::out_item_t expected_readings[$];
  mcc_pkg::out_item_t oldest_reading;

  int          mismatches;
  int          results_checked;
  int          items_sent;
  int          sets_sent;
  int          ticks_sent;
  int          second_carries;
  int          day_carries;
  int          burst_left;

  // ---------------------------------------------------------------------------
  // calendar prediction
  // ---------------------------------------------------------------------------

  // gregorian leap rule
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // days in a month, zero for a month code outside 1..12
  function automatic int unsigned days_in(input int unsigned mon, input bit leap);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return 28 + leap;
      default:               return 0;
    endcase
  endfunction

  function automatic void reset_calendar();
    clock_ms    = '0;
    cal_sec     = 0;
    cal_min     = 0;
    cal_hour    = 0;
    cal_wday    = 1;
    cal_mday    = 1;
    cal_month   = 1;
    cal_year    = 2000;
    cal_leap    = 1'b1;
    cal_running = 1'b1;
  endfunction

  function automatic void bump_day();
    int unsigned next_day;
    int unsigned len;
    next_day = cal_mday + 1;
    day_carries++;
    // weekday wraps to 1 from 7 and above, and from 0
    cal_wday = (cal_wday >= 7 || cal_wday == 0) ? 1 : cal_wday + 1;
    // bogus month code: the day just counts modulo 32, month and year hold
    if (cal_month < 1 || cal_month > 12) begin
      cal_mday = next_day & 31;
      return;
    end
    len = days_in(cal_month, cal_leap);
    // compared before truncation, so a loaded day 31 in a 30-day month rolls
    if (next_day > len) begin
      cal_mday = 1;
      if (cal_month == 12) begin
        cal_month = 1;
        cal_year  = (cal_year + 1) & 16'hFFFF;
        cal_leap  = leap_year(cal_year);
      end else begin
        cal_month = cal_month + 1;
      end
    end else begin
      cal_mday = next_day;
    end
  endfunction

  function automatic void bump_second();
    second_carries++;
    cal_sec = cal_sec + 1;
    if (cal_sec < 60) return;
    cal_sec = 0;
    cal_min = cal_min + 1;
    if (cal_min < 60) return;
    cal_min  = 0;
    cal_hour = cal_hour + 1;
    if (cal_hour < 24) return;
    cal_hour = 0;
    bump_day();
  endfunction

  // apply one command to the predicted calendar and return the reading
  function automatic mcc_pkg::out_item_t calendar_apply(input mcc_pkg::in_item_t item);
    mcc_pkg::out_item_t r;
    case (item.command)
      mcc_pkg::CMD_TICK: begin
        ticks_sent++;
        if (cal_running) begin
          // wrap to zero lands on a second boundary too
          clock_ms = clock_ms + 64'd1;
          if (clock_ms % 64'(mcc_pkg::MS_PER_SECOND) == 64'd0) bump_second();
        end
      end
      mcc_pkg::CMD_SET: begin
        sets_sent++;
        clock_ms  = item.new_timestamp;
        cal_sec   = 32'(item.new_second);
        cal_min   = 32'(item.new_minute);
        cal_hour  = 32'(item.new_hour);
        cal_wday  = 32'(item.new_week_day);
        cal_mday  = 32'(item.new_month_day);
        cal_month = 32'(item.new_month);
        cal_year  = 32'(item.new_year);
        cal_leap  = leap_year(cal_year);
      end
      mcc_pkg::CMD_START: cal_running = 1'b1;
      mcc_pkg::CMD_STOP:  cal_running = 1'b0;
      default:            cal_running = cal_running;
    endcase
    r.now_timestamp = clock_ms;
    r.now_second    = 6'(cal_sec);
    r.now_minute    = 6'(cal_min);
    r.now_hour      = 5'(cal_hour);
    r.now_week_day  = 3'(cal_wday);
    r.now_month_day = 5'(cal_mday);
    r.now_month     = 4'(cal_month);
    r.now_year      = 16'(cal_year);
    r.is_running    = cal_running;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  // any command with a random payload, so unused fields toggle too
  function automatic mcc_pkg::in_item_t make_cmd(input mcc_pkg::cmd_t c);
    logic [127:0]      raw;
    mcc_pkg::in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(mcc_pkg::in_item_t)-1:0];
    it.command = c;
    return it;
  endfunction

  function automatic mcc_pkg::in_item_t make_set(input logic [63:0] ts, input int unsigned s,
                                        input int unsigned m, input int unsigned h,
                                        input int unsigned wd, input int unsigned md,
                                        input int unsigned mon, input int unsigned yr);
    mcc_pkg::in_item_t it;
    it = make_cmd(mcc_pkg::CMD_SET);
    it.new_timestamp = ts;
    it.new_second    = 6'(s);
    it.new_minute    = 6'(m);
    it.new_hour      = 5'(h);
    it.new_week_day  = 3'(wd);
    it.new_month_day = 5'(md);
    it.new_month     = 4'(mon);
    it.new_year      = 16'(yr);
    return it;
  endfunction

  // set a few ms short of a second boundary, with the date often at the
  // edge of a minute, hour, day, month or year
  function automatic mcc_pkg::in_item_t near_boundary_set();
    logic [63:0] base;
    logic [63:0] ts;
    int unsigned yr, mon, len, md;
    if ($urandom_range(0, 19) == 0) begin
      ts = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 8));
    end else begin
      base = {$urandom, $urandom};
      ts   = base - base % 64'd1000 + 64'd1000 - 64'($urandom_range(1, 8));
    end
    case ($urandom_range(0, 7))
      0:       yr = 1900;
      1:       yr = 2000;
      2:       yr = 2100;
      3:       yr = 2024;
      4:       yr = 2023;
      5:       yr = 65535;
      6:       yr = 0;
      default: yr = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 15))
      0:             mon = $urandom_range(13, 15);
      1:             mon = 0;
      2, 3, 4, 5:    mon = 12;
      6, 7:          mon = 2;
      default:       mon = $urandom_range(1, 12);
    endcase
    len = days_in(mon, leap_year(yr));
    if (len == 0)              md = $urandom_range(0, 31);
    else if ($urandom_range(0, 1)) md = len;
    else                       md = $urandom_range(1, len);
    return make_set(ts,
                    $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                    $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                    $urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
                    $urandom_range(1, 7), md, mon, yr);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  task automatic send_command(input mcc_pkg::in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // values read right after the edge are the ones the block saw
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(calendar_apply(item));
    burst_left--;
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stalls in modes of random length
  // ---------------------------------------------------------------------------
  int ready_mode;
  int ready_left;

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(20, 200);
    end
    ready_left--;
    case (ready_mode)
      0:       out_ready <= 1'b1;                       // no backpressure
      1:       out_ready <= 1'($urandom_range(0, 1));   // coin flip
      default: out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
    endcase
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // sampled in the active region, so outputs read here are pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("result transfer with nothing pending", '0, '0);
      end else begin
        oldest_reading = expected_readings.pop_front();
        check_field("now_timestamp", out_data.now_timestamp, oldest_reading.now_timestamp);
        check_field("now_second", 64'(out_data.now_second),
                    64'(oldest_reading.now_second));
        check_field("now_minute", 64'(out_data.now_minute),
                    64'(oldest_reading.now_minute));
        check_field("now_hour", 64'(out_data.now_hour),
                    64'(oldest_reading.now_hour));
        check_field("now_week_day", 64'(out_data.now_week_day),
                    64'(oldest_reading.now_week_day));
        check_field("now_month_day", 64'(out_data.now_month_day),
                    64'(oldest_reading.now_month_day));
        check_field("now_month", 64'(out_data.now_month),
                    64'(oldest_reading.now_month));
        check_field("now_year", 64'(out_data.now_year),
                    64'(oldest_reading.now_year));
        check_field("is_running", 64'(out_data.is_running),
                    64'(oldest_reading.is_running));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // tick from reset, stop holds the clock, commands accepted while stopped
  task automatic test_run_control();
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    send_command(make_cmd(mcc_pkg::CMD_STOP));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    send_command(make_set(64'd999, 59, 59, 23, 3, 15, 6, 2021));
    send_command(make_cmd(mcc_pkg::CMD_TICK));   // stopped: no second carry
    send_command(make_cmd(mcc_pkg::CMD_STOP));
    send_command(make_cmd(mcc_pkg::CMD_START));
    send_command(make_cmd(mcc_pkg::CMD_START));
    send_command(make_cmd(mcc_pkg::CMD_TICK));   // now the carry happens
  endtask

  // timestamp wraps to zero and the carry runs all the way to the year
  task automatic test_full_rollover();
    send_command(make_set(64'hFFFF_FFFF_FFFF_FFFF, 59, 59, 23, 7, 31, 12, 65535));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    // all-ones fields: second, minute, hour and month out of range at once
    send_command(make_set(64'hFFFF_FFFF_FFFF_FFFF, 63, 63, 31, 7, 31, 15, 65535));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
  endtask

  // february in leap and non-leap years, and an over-long loaded day
  task automatic test_month_ends();
    send_command(make_set(64'd999, 59, 59, 23, 4, 28, 2, 2024));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    send_command(make_set(64'd1999, 59, 59, 23, 5, 28, 2, 2100));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    send_command(make_set(64'd2999, 59, 59, 23, 6, 28, 2, 2400));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    send_command(make_set(64'd3999, 59, 59, 23, 2, 31, 4, 2023));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
  endtask

  // loaded fields outside their ranges
  task automatic test_out_of_range();
    send_command(make_set(64'd999, 63, 63, 31, 0, 31, 0, 1999));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    send_command(make_set(64'd999, 59, 59, 23, 7, 5, 13, 1600));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
    send_command(make_set(64'd0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(mcc_pkg::CMD_TICK));
  endtask

  // mostly a set near a boundary followed by a run of ticks, with the odd
  // stop and start mixed in; the rest is noise with fully random payloads
  task automatic test_random_calendar(input int item_goal);
    int first;
    int n;
    int k;
    first = items_sent;
    while (items_sent - first < item_goal) begin
      if ($urandom_range(0, 9) < 8) begin
        send_command(near_boundary_set());
        n = $urandom_range(1, 25);
        repeat (n) begin
          k = $urandom_range(0, 19);
          if (k == 0)      send_command(make_cmd(mcc_pkg::CMD_STOP));
          else if (k == 1) send_command(make_cmd(mcc_pkg::CMD_START));
          else             send_command(make_cmd(mcc_pkg::CMD_TICK));
        end
        if ($urandom_range(0, 1)) send_command(make_cmd(mcc_pkg::CMD_START));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_command(make_cmd(mcc_pkg::cmd_t'($urandom_range(0, 3))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_calendar();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_run_control();
    test_full_rollover();
    test_month_ends();
    test_out_of_range();
    test_random_calendar(1650);

    // last transfer done, drop valid and drain the pipeline
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d commands: %0d sets, %0d ticks, %0d second carries, %0d day carries",
             items_sent, sets_sent, ticks_sent, second_carries, day_carries);
    $display("checked %0d results, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results still pending", expected_readings.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
sv/mcc_pkg.sv
sv/mcc_mod_stage.sv
sv/mcc_calendar.sv
sv/millisecond_calendar_counter.sv
tb/millisecond_calendar_counter_tb.sv
